@@ src/mtg_pkg.sv @@
// Shared types, constants and the tempering function of the Mersenne Twister generator.
`default_nettype none

package mtg_pkg;

  localparam logic [31:0] MT_MATRIX       = 32'h9908_b0df;
  localparam logic [31:0] MT_UPPER        = 32'h8000_0000;
  localparam logic [31:0] MT_LOWER        = 32'h7fff_ffff;
  localparam logic [31:0] MT_SEED_MUL     = 32'd1664525;
  localparam logic [31:0] MT_DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] MT_TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] MT_TEMPER_C     = 32'hefc6_0000;

  // APB register map
  localparam logic REG_SEED_VALUE = 1'b0;

  // Action codes carried in tuser
  localparam logic ACT_RESEED = 1'b0;
  localparam logic ACT_DRAW   = 1'b1;

  typedef struct packed {
    logic draw;
    logic narrow;
  } mtg_cmd_t;

  function automatic logic [31:0] mt_temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & MT_TEMPER_B);
    y = y ^ ((y << 15) & MT_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

@@ src/mtg_front.sv @@
// Front end: takes input transfers, decodes them into commands and queues two of them.
`default_nettype none

module mtg_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  output logic                   s_ready_o,
  input  wire logic              action_i,
  input  wire logic              narrow_i,
  output logic                   cmd_valid_o,
  output mtg_pkg::mtg_cmd_t      cmd_o,
  input  wire logic              cmd_pop_i
);
  import mtg_pkg::*;

  mtg_cmd_t   queue_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;
  mtg_cmd_t   cmd_in;

  assign s_ready_o   = (count_q != 2'd2);
  assign push        = s_valid_i && s_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    cmd_in.draw   = (action_i == ACT_DRAW);
    cmd_in.narrow = narrow_i;
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

@@ src/mtg_back.sv @@
// Back end: state table memory, seeding and twist sequencer, draw path and result register.
`default_nettype none

module mtg_back #(
  parameter int STATE_WORDS  = 624,
  parameter int TWIST_OFFSET = 397
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire mtg_pkg::mtg_cmd_t cmd_i,
  output logic                   cmd_pop_o,
  input  wire logic [31:0]       seed_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [31:0]            out_data_o
);
  import mtg_pkg::*;

  localparam int IW = $clog2(STATE_WORDS);
  localparam int PW = $clog2(STATE_WORDS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(STATE_WORDS - 1);
  localparam logic [IW:0]   WORDS_W  = (IW + 1)'(STATE_WORDS);
  localparam logic [IW:0]   OFFS_W   = (IW + 1)'(TWIST_OFFSET);
  localparam logic [PW-1:0] POS_END  = PW'(STATE_WORDS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEED  = 3'd1;
  localparam logic [2:0] S_TPREP = 3'd2;
  localparam logic [2:0] S_TWIST = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_TEMP  = 3'd5;

  logic [31:0]   twister_mem [STATE_WORDS];

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          phase_q, phase_d;
  logic [31:0]   cur_q, cur_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          seeded_q, seeded_d;
  logic          draw_q, draw_d;
  logic          narrow_q, narrow_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_data_q, out_data_d;
  logic [31:0]   rd_a_q, rd_b_q;

  logic          we;
  logic [IW-1:0] waddr;
  logic [31:0]   wdata;
  logic          re;
  logic [IW-1:0] raddr_a, raddr_b;

  logic [IW-1:0] next_idx;
  logic [IW:0]   far_sum;
  logic [IW-1:0] far_idx;
  logic [31:0]   seed_next;
  logic [31:0]   twist_y;
  logic [31:0]   twist_word;
  logic [31:0]   tempered;
  logic          out_free;

  assign next_idx   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign far_sum    = {1'b0, idx_q} + OFFS_W;
  assign far_idx    = (far_sum >= WORDS_W) ? IW'(far_sum - WORDS_W) : far_sum[IW-1:0];
  assign seed_next  = cur_q * MT_SEED_MUL + 32'd1;
  assign twist_y    = (cur_q & MT_UPPER) | (rd_a_q & MT_LOWER);
  assign twist_word = rd_b_q ^ (twist_y >> 1) ^ (twist_y[0] ? MT_MATRIX : 32'd0);
  assign tempered   = mt_temper(rd_a_q);
  assign out_free   = !out_valid_q || out_ready_i;

  assign cmd_pop_o   = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    cur_d       = cur_q;
    pos_d       = pos_q;
    seeded_d    = seeded_q;
    draw_d      = draw_q;
    narrow_d    = narrow_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = cur_q;
    re          = 1'b0;
    raddr_a     = next_idx;
    raddr_b     = far_idx;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          idx_d    = '0;
          draw_d   = cmd_i.draw;
          narrow_d = cmd_i.narrow;
          if (!cmd_i.draw) begin
            cur_d   = seed_i;
            state_d = S_SEED;
          end else if (!seeded_q) begin
            cur_d   = MT_DEFAULT_SEED;
            state_d = S_SEED;
          end else if (pos_q == POS_END) begin
            state_d = S_TPREP;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_SEED: begin
        we    = 1'b1;
        cur_d = seed_next;
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d    = '0;
          pos_d    = POS_END;
          seeded_d = 1'b1;
          state_d  = draw_q ? S_TPREP : S_IDLE;
        end
      end
      S_TPREP: begin
        // fetch word 0 so the first step has its upper bit
        re      = 1'b1;
        raddr_a = '0;
        idx_d   = '0;
        phase_d = 1'b0;
        state_d = S_TWIST;
      end
      S_TWIST: begin
        if (!phase_q) begin
          re      = 1'b1;
          phase_d = 1'b1;
          if (idx_q == '0) begin
            cur_d = rd_a_q;
          end
        end else begin
          // rd_a holds the old neighbor, carried as the next step's own word
          we      = 1'b1;
          wdata   = twist_word;
          cur_d   = rd_a_q;
          phase_d = 1'b0;
          if (idx_q == LAST_IDX) begin
            pos_d   = '0;
            state_d = S_READ;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_READ: begin
        re      = 1'b1;
        raddr_a = pos_q[IW-1:0];
        state_d = S_TEMP;
      end
      S_TEMP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = narrow_q ? (tempered >> 1) : tempered;
          pos_d       = pos_q + 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      phase_q     <= 1'b0;
      pos_q       <= POS_END;
      seeded_q    <= 1'b0;
      draw_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      seeded_q    <= seeded_d;
      draw_q      <= draw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    narrow_q   <= narrow_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      twister_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_a_q <= twister_mem[raddr_a];
      rd_b_q <= twister_mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

@@ src/mersenne_twister_generator.sv @@
// Top level of the Mersenne Twister generator: APB seed register, front queue and back end.
//
// Input stream: tuser[0] is the action (0 reseed, 1 draw), tdata[0] is the narrow flag.
// Output stream: tdata carries one 32-bit tempered word per draw; a reseed gives nothing.
// seed_value sits at APB byte address 0 (reset 5489); write it only while the block is idle.
// Commands pass through a two-entry queue, so the input is taken while the back end works
// or while a result waits in the output register.
// A draw goes through the back end as queue pop, table read, then temper into the output
// register, which waits while that register is full; the next command is popped only in idle.
// After every STATE_WORDS draws, and on the first draw after a reseed, the table is
// twisted first: a prep read of word 0, then a read phase and a write phase per word.
// A reseed fills the table one word a cycle, all STATE_WORDS words.
// A draw before any reseed seeds with 5489 first, then twists.
// Reset empties the queue, clears the output and marks the table unseeded; the table memory
// itself is not cleared.
// When the receiver stalls, the finished word holds in the output register and the back end
// waits before writing the next one; the queue fills and then drops tready.
`default_nettype none

module mersenne_twister_generator #(
  parameter int STATE_WORDS  = 624,
  parameter int TWIST_OFFSET = 397
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [0] narrow, [7:1] zero
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] action
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] random_word
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mtg_pkg::*;

  logic [31:0] seed_q, seed_d;
  logic        reg_hit;
  logic        cmd_valid;
  logic        cmd_pop;
  mtg_cmd_t    cmd;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_SEED_VALUE);
  assign seed_d  = (psel && penable && pwrite && pready && reg_hit) ? pwdata : seed_q;
  assign prdata  = reg_hit ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= MT_DEFAULT_SEED;
    end else begin
      seed_q <= seed_d;
    end
  end

  mtg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .action_i    (s_axis_tuser_i[0]),
    .narrow_i    (s_axis_tdata_i[0]),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mtg_back #(
    .STATE_WORDS  (STATE_WORDS),
    .TWIST_OFFSET (TWIST_OFFSET)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .seed_i      (seed_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

@@ src/mtg_checker.sv @@
// Port-level checks for the Mersenne Twister generator, bound to the top level.
`default_nettype none

module mtg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [7:0]  s_axis_tdata_i,
  input wire logic [0:0]  s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);
  import mtg_pkg::*;

  // a stalled result keeps its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a waiting input transfer keeps its fields
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=>
      s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tuser_i))
    else $error("input changed while waiting");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // the seed register reads back what was just written
  a_seed_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] == REG_SEED_VALUE
      ##1 paddr[2] == REG_SEED_VALUE
      |-> prdata == $past(pwdata))
    else $error("seed register readback mismatch");

  // no result can be ready right after reset is released
  a_idle_after_reset: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid right after reset");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);

`default_nettype wire

@@ sim/tb_mersenne_twister_generator.sv @@
// Self-checking testbench for the Mersenne Twister generator: stream and APB stimulus, scoreboard.
`timescale 1ns / 1ps

module tb_mersenne_twister_generator;
  import mtg_pkg::*;

  localparam int TABLE_WORDS  = 624;
  localparam int TWIST_STEP   = 397;
  // reseed fill, plus a twist, plus margin: enough for any work left with no result pending
  localparam int SETTLE_CYCLES = 3 * TABLE_WORDS + 64;
  localparam int GAP_PCT       = 23;
  localparam int MAX_REPORTS   = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [0] narrow, [7:1] zero
  logic [0:0]  s_axis_tuser_i;   // [0] action
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [31:0] random_word
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mersenne_twister_generator #(
    .STATE_WORDS (TABLE_WORDS),
    .TWIST_OFFSET(TWIST_STEP)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Generator shadow state
  logic [31:0] mt_words [TABLE_WORDS];
  int          mt_pos;
  bit          mt_seeded;
  logic [31:0] seed_shadow;
  logic [31:0] expected_words [$];

  int stall_pct;
  int mismatch_count;
  int draws_sent, narrow_sent, reseeds_sent, twists_done, seed_writes, words_checked;
  logic [31:0] want_word;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d words still pending", expected_words.size());
    $display("mersenne_twister_generator: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t ns: %s: got %08h, want %08h", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------- prediction ----------------

  function automatic void fill_words(input logic [31:0] seed);
    mt_words[0] = seed;
    for (int i = 1; i < TABLE_WORDS; i++)
      mt_words[i] = mt_words[i-1] * MT_SEED_MUL + 32'd1;
    mt_pos    = TABLE_WORDS;
    mt_seeded = 1'b1;
  endfunction

  function automatic void twist_words();
    logic [31:0] mixed;
    int nxt, far;
    for (int k = 0; k < TABLE_WORDS; k++) begin
      nxt   = (k + 1) % TABLE_WORDS;
      far   = (k + TWIST_STEP) % TABLE_WORDS;
      mixed = (mt_words[k] & MT_UPPER) | (mt_words[nxt] & MT_LOWER);
      mt_words[k] = mt_words[far] ^ {1'b0, mixed[31:1]} ^ (mixed[0] ? MT_MATRIX : 32'd0);
    end
    mt_pos = 0;
    twists_done++;
  endfunction

  function automatic logic [31:0] tempered(input logic [31:0] raw);
    logic [31:0] t;
    t = raw;
    t = t ^ {11'b0, t[31:11]};
    t = t ^ ({t[24:0], 7'b0} & MT_TEMPER_B);
    t = t ^ ({t[16:0], 15'b0} & MT_TEMPER_C);
    t = t ^ {18'b0, t[31:18]};
    return t;
  endfunction

  function automatic void predict_command(input logic action, input logic narrow);
    logic [31:0] word;
    if (action == ACT_RESEED) begin
      fill_words(seed_shadow);
      reseeds_sent++;
      return;
    end
    if (!mt_seeded) fill_words(MT_DEFAULT_SEED);
    if (mt_pos >= TABLE_WORDS) twist_words();
    word = tempered(mt_words[mt_pos]);
    mt_pos++;
    if (narrow) word = {1'b0, word[31:1]};
    expected_words.push_back(word);
    draws_sent++;
    if (narrow) narrow_sent++;
  endfunction

  // ---------------- stream side ----------------

  task automatic send_command(input logic action, input logic narrow);
    while (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= action;
    s_axis_tdata_i  <= {7'b0, narrow};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_command(action, narrow);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected", m_axis_tdata_o, 32'd0);
      end else begin
        want_word = expected_words.pop_front();
        words_checked++;
        if (m_axis_tdata_o !== want_word)
          report_mismatch("random_word", m_axis_tdata_o, want_word);
      end
    end
  end

  // drain results, then give a trailing reseed or twist time to finish
  task automatic wait_until_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------- APB side ----------------

  task automatic write_seed(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SEED_VALUE, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seed_shadow = value;
    seed_writes++;
  endtask

  task automatic check_seed_readback();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_SEED_VALUE, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== seed_shadow) report_mismatch("seed_value readback", prdata, seed_shadow);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------- tests ----------------

  // draws with no reseed yet: the block seeds itself with the default seed
  task automatic test_draw_before_seed();
    check_seed_readback();
    send_command(ACT_DRAW, 1'b0);
    send_command(ACT_DRAW, 1'b1);
    repeat (3) send_command(ACT_DRAW, 1'b0);
    wait_until_idle();
  endtask

  task automatic test_seed_extremes();
    logic [31:0] seeds [3];
    seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      check_seed_readback();
      send_command(ACT_RESEED, 1'(i));  // narrow must be ignored on a reseed
      send_command(ACT_DRAW, 1'b0);
      send_command(ACT_DRAW, 1'b1);
      wait_until_idle();
    end
    // back-to-back reseeds, then draws right behind them
    write_seed(32'd1);
    send_command(ACT_RESEED, 1'b0);
    send_command(ACT_RESEED, 1'b1);
    send_command(ACT_DRAW, 1'b1);
    send_command(ACT_DRAW, 1'b0);
    wait_until_idle();
  endtask

  // run past the end of the table so the second twist happens mid-stream
  task automatic test_table_wrap();
    write_seed($urandom);
    send_command(ACT_RESEED, 1'($urandom_range(1)));
    stall_pct = 0;
    for (int i = 0; i < 300; i++) send_command(ACT_DRAW, 1'($urandom_range(1)));
    stall_pct = GAP_PCT;
    for (int i = 0; i < 350; i++) send_command(ACT_DRAW, 1'($urandom_range(1)));
    wait_until_idle();
  endtask

  task automatic test_random_mix();
    logic action;
    for (int phase = 0; phase < 4; phase++) begin
      write_seed(phase == 3 ? 32'hffff_ffff : $urandom);
      for (int i = 0; i < 95; i++) begin
        action = ($urandom_range(99) < 6) ? ACT_RESEED : ACT_DRAW;
        send_command(action, 1'($urandom_range(1)));
      end
      wait_until_idle();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = ACT_DRAW;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    stall_pct       = GAP_PCT;
    seed_shadow     = MT_DEFAULT_SEED;
    mt_pos          = TABLE_WORDS;
    mt_seeded       = 1'b0;
    mismatch_count  = 0;
    draws_sent      = 0;
    narrow_sent     = 0;
    reseeds_sent    = 0;
    twists_done     = 0;
    seed_writes     = 0;
    words_checked   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_draw_before_seed();
    test_seed_extremes();
    test_table_wrap();
    test_random_mix();

    $display("covered %0d draws (%0d narrow), %0d reseeds, %0d seed writes, %0d table twists",
             draws_sent, narrow_sent, reseeds_sent, seed_writes, twists_done);
    $display("compared %0d words, %0d mismatches", words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("mersenne_twister_generator: match");
    end else begin
      $display("mersenne_twister_generator: mismatch");
    end
    $finish;
  end

endmodule
